// File: hdl/lswr_pkg.sv
// shared types, constants, wave table and microprogram of the wave rainbow animator
package lswr_pkg;

    localparam int MAX_LEDS        = 256;
    localparam int WAVE_TABLE_SIZE = 256;
    localparam int WAVE_IDX_W      = $clog2(WAVE_TABLE_SIZE);
    localparam int LEN_W           = 9;
    localparam int PHASE_W         = 8;
    localparam int POS_W           = 10;
    localparam int REP_W           = 4;
    localparam int REP_MAX         = 8;
    localparam int SEED_W          = 31;
    localparam int SLOW_W          = 8;
    localparam int PIX_W           = 8;
    localparam int RGB_W           = 24;
    localparam int RAINBOW_COLORS  = 6;
    localparam int COLOR_IDX_W     = 3;

    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = 3;

    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 32;

    localparam int DIV_W           = 32;
    localparam int DIV_NARROW_W    = 16;
    localparam int DIVR_W          = 9;
    localparam int DIV_CNT_W       = $clog2(DIV_W + 1);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_STRIP_LENGTH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEED         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SLOWDOWN     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RETRIGGER    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_REPEAT = 3'd5;

    localparam logic [RGB_W-1:0] RAINBOW [RAINBOW_COLORS] = '{
        24'hA000FF, 24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF9000, 24'hFF0000
    };

    // cosine table build, evaluated at elaboration only
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint WAVE_BASE   = 64'sd64;
    localparam longint WAVE_AMP    = 64'sd63;
    localparam int     TAYLOR_TERMS = 10;
    localparam longint TAYLOR_DEN [TAYLOR_TERMS] = '{
        64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
        64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380
    };

    function automatic logic [7:0] wave_point(input int k);
        longint n;
        longint p;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint c;
        longint t;
        bit     neg;
        int     i;
        t   = longint'(WAVE_TABLE_SIZE);
        n   = longint'(k);
        neg = 1'b0;
        if (2 * n > t) n = t - n;
        p = 4 * n;
        if (p > t) begin
            p   = 2 * t - p;
            neg = 1'b1;
        end
        if (p == 0) begin
            c = Q30_ONE;
        end else if (p == t) begin
            c = 0;
        end else begin
            x    = (p * HALF_PI_Q30) / WAVE_TABLE_SIZE;
            x2   = (x * x) >>> 30;
            term = Q30_ONE;
            sum  = Q30_ONE;
            for (i = 0; i < TAYLOR_TERMS; i++) begin
                term = (term * x2) >>> 30;
                term = term / TAYLOR_DEN[i];
                if (i[0] == 1'b0) sum = sum - term;
                else sum = sum + term;
            end
            if (sum < 0) sum = 0;
            if (sum > Q30_ONE) sum = Q30_ONE;
            c = sum;
        end
        if (neg) c = -c;
        return 8'(WAVE_BASE + (((Q30_ONE + c) * WAVE_AMP) >>> 30));
    endfunction

    function automatic logic [WAVE_TABLE_SIZE*8-1:0] wave_rom_build();
        logic [WAVE_TABLE_SIZE*8-1:0] rom;
        int k;
        rom = '0;
        for (k = 0; k < WAVE_TABLE_SIZE; k++) begin
            rom[k*8 +: 8] = wave_point(k);
        end
        return rom;
    endfunction

    localparam logic [WAVE_TABLE_SIZE*8-1:0] WAVE_ROM = wave_rom_build();

    typedef struct packed {
        logic [LEN_W-1:0]  strip_length;
        logic              forward;
        logic [SEED_W-1:0] seed;
        logic [SLOW_W-1:0] slowdown;
        logic              retrigger;
        logic [REP_W-1:0]  pixel_repeat;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              narrow;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIV_W-1:0]  quo;
        logic [DIVR_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic in_valid;
        logic in_read;
        logic div_busy;
        logic rem_nz;
        logic no_pixel;
        logic out_free;
    } t_stat;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_TICK_START,
        ACT_PHASE_DIV,
        ACT_DRAW,
        ACT_IDX_DIV,
        ACT_SCALE_DIV,
        ACT_COLOR,
        ACT_EMIT
    } t_act;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_DIV_WAIT,
        COND_INPUT,
        COND_REM_NZ,
        COND_NO_PIXEL,
        COND_OUT_WAIT
    } t_cond;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step STEP_IDLE       = 4'd0;
    localparam t_step STEP_TICK       = 4'd1;
    localparam t_step STEP_TICK_WAIT  = 4'd2;
    localparam t_step STEP_SLOT       = 4'd3;
    localparam t_step STEP_PHASE      = 4'd4;
    localparam t_step STEP_PHASE_WAIT = 4'd5;
    localparam t_step STEP_DRAW       = 4'd6;
    localparam t_step STEP_READ       = 4'd7;
    localparam t_step STEP_IDX_WAIT   = 4'd8;
    localparam t_step STEP_SCALE      = 4'd9;
    localparam t_step STEP_SCALE_WAIT = 4'd10;
    localparam t_step STEP_COLOR      = 4'd11;
    localparam t_step STEP_EMIT       = 4'd12;

    function automatic t_uword uw(input t_act a, input t_cond c, input t_step t);
        t_uword w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input t_step a);
        t_uword w;
        unique case (a)
            STEP_IDLE:       w = uw(ACT_ACCEPT,     COND_INPUT,    STEP_READ);
            STEP_TICK:       w = uw(ACT_TICK_START, COND_NEXT,     STEP_IDLE);
            STEP_TICK_WAIT:  w = uw(ACT_NONE,       COND_DIV_WAIT, STEP_IDLE);
            STEP_SLOT:       w = uw(ACT_NONE,       COND_REM_NZ,   STEP_EMIT);
            STEP_PHASE:      w = uw(ACT_PHASE_DIV,  COND_NEXT,     STEP_IDLE);
            STEP_PHASE_WAIT: w = uw(ACT_NONE,       COND_DIV_WAIT, STEP_IDLE);
            STEP_DRAW:       w = uw(ACT_DRAW,       COND_GOTO,     STEP_EMIT);
            STEP_READ:       w = uw(ACT_IDX_DIV,    COND_NO_PIXEL, STEP_EMIT);
            STEP_IDX_WAIT:   w = uw(ACT_NONE,       COND_DIV_WAIT, STEP_IDLE);
            STEP_SCALE:      w = uw(ACT_SCALE_DIV,  COND_NEXT,     STEP_IDLE);
            STEP_SCALE_WAIT: w = uw(ACT_NONE,       COND_DIV_WAIT, STEP_IDLE);
            STEP_COLOR:      w = uw(ACT_COLOR,      COND_NEXT,     STEP_IDLE);
            STEP_EMIT:       w = uw(ACT_EMIT,       COND_OUT_WAIT, STEP_IDLE);
            default:         w = uw(ACT_NONE,       COND_GOTO,     STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// File: hdl/lswr_cfg.sv
// apb configuration registers of the wave rainbow animator
module lswr_cfg
    import lswr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strip_length <= LEN_W'(240);
            r_cfg.forward      <= 1'b1;
            r_cfg.seed         <= '0;
            r_cfg.slowdown     <= SLOW_W'(2);
            r_cfg.retrigger    <= 1'b0;
            r_cfg.pixel_repeat <= REP_W'(2);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STRIP_LENGTH: r_cfg.strip_length <= pwdata[LEN_W-1:0];
                REG_FORWARD:      r_cfg.forward      <= pwdata[0];
                REG_SEED:         r_cfg.seed         <= pwdata[SEED_W-1:0];
                REG_SLOWDOWN:     r_cfg.slowdown     <= pwdata[SLOW_W-1:0];
                REG_RETRIGGER:    r_cfg.retrigger    <= pwdata[0];
                REG_PIXEL_REPEAT: r_cfg.pixel_repeat <= pwdata[REP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STRIP_LENGTH: prdata = APB_DATA_W'(r_cfg.strip_length);
            REG_FORWARD:      prdata = APB_DATA_W'(r_cfg.forward);
            REG_SEED:         prdata = APB_DATA_W'(r_cfg.seed);
            REG_SLOWDOWN:     prdata = APB_DATA_W'(r_cfg.slowdown);
            REG_RETRIGGER:    prdata = APB_DATA_W'(r_cfg.retrigger);
            REG_PIXEL_REPEAT: prdata = APB_DATA_W'(r_cfg.pixel_repeat);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: hdl/lswr_div.sv
// bit-serial restoring divider giving quotient and remainder
module lswr_div
    import lswr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DIVR_W-1:0]    r_rem;
    logic [DIVR_W-1:0]    r_den;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic                 ge;
    logic                 busy;

    assign busy  = (r_cnt != '0);
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.load) begin
            r_cnt <= i_req.narrow ? DIV_CNT_W'(DIV_NARROW_W) : DIV_CNT_W'(DIV_W);
        end else if (busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_quo <= i_req.narrow ?
                     {i_req.dividend[DIV_NARROW_W-1:0], (DIV_W-DIV_NARROW_W)'(0)} :
                     i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        end
    end

    assign o_rsp.busy = busy;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.load |=> busy)
        else $error("divider not busy after load");

endmodule

// File: hdl/lswr_useq.sv
// microprogram sequencer: step counter, control rom and conditional jumps
module lswr_useq
    import lswr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_act  o_act
);

    t_step  r_step;
    t_step  n_step;
    t_uword word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        word   = ucode_rom(r_step);
        n_step = r_step + t_step'(1);
        unique case (word.cond)
            COND_NEXT:     n_step = r_step + t_step'(1);
            COND_GOTO:     n_step = word.target;
            COND_DIV_WAIT: if (i_stat.div_busy) n_step = r_step;
            COND_INPUT: begin
                if (!i_stat.in_valid) n_step = r_step;
                else if (i_stat.in_read) n_step = word.target;
            end
            COND_REM_NZ:   if (i_stat.rem_nz) n_step = word.target;
            COND_NO_PIXEL: if (i_stat.no_pixel) n_step = word.target;
            COND_OUT_WAIT: n_step = i_stat.out_free ? word.target : r_step;
            default:       n_step = STEP_IDLE;
        endcase
    end

    assign o_act = word.act;

endmodule

// File: hdl/lswr_dpath.sv
// datapath: animation state, latched frame, pixel color and output register
module lswr_dpath
    import lswr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_act                  i_act,
    input  t_cfg                  i_cfg,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // touch, pixel_index
    input  logic [0:0]            s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // sweep_done, redrawn, color
    output t_div_req              o_div_req,
    input  t_div_rsp              i_div_rsp,
    output t_stat                 o_stat
);

    logic [PIX_W-1:0]      r_pix;
    logic                  r_touch;
    logic [31:0]           r_clock;
    logic signed [POS_W-1:0] r_sweep_pos;
    logic [PHASE_W-1:0]    r_phase;
    logic [POS_W-1:0]      r_dpos;
    logic                  r_dactive;
    logic                  r_fvalid;
    logic [LEN_W-1:0]      r_dlen;
    logic                  r_dfwd;
    logic [REP_W-1:0]      r_drep;
    logic                  r_res_done;
    logic                  r_res_redrawn;
    logic [RGB_W-1:0]      r_res_color;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  accept;
    logic                  out_free;
    logic                  emit;
    logic [LEN_W-1:0]      len_eff;
    logic [DIVR_W-1:0]     sd_eff;
    logic [REP_W-1:0]      rep_eff;
    logic                  touch_hit;
    logic                  sweep_idle;
    logic [POS_W-1:0]      idx_sum;
    logic [7:0]            wave_val;
    logic signed [10:0]    slot;
    logic [5:0]            slot_cnt;
    logic                  in_band;
    logic [COLOR_IDX_W-1:0] cidx;
    logic [RGB_W-1:0]      pix_rgb;

    assign accept   = s_axis_tready && s_axis_tvalid;
    assign out_free = !r_out_valid || m_axis_tready;
    assign emit     = (i_act == ACT_EMIT) && out_free;

    assign s_axis_tready = i_rst_n && (i_act == ACT_ACCEPT);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        if (i_cfg.strip_length == '0) len_eff = LEN_W'(1);
        else if (i_cfg.strip_length > LEN_W'(MAX_LEDS)) len_eff = LEN_W'(MAX_LEDS);
        else len_eff = i_cfg.strip_length;
        sd_eff = (i_cfg.slowdown == '0) ? DIVR_W'(1) : DIVR_W'(i_cfg.slowdown);
        if (i_cfg.pixel_repeat == '0) rep_eff = REP_W'(1);
        else if (i_cfg.pixel_repeat > REP_W'(REP_MAX)) rep_eff = REP_W'(REP_MAX);
        else rep_eff = i_cfg.pixel_repeat;
    end

    assign sweep_idle = r_sweep_pos[POS_W-1];
    assign touch_hit  = r_touch && (i_cfg.retrigger || sweep_idle);
    assign idx_sum    = POS_W'(r_pix) + {1'b0, r_pix, 1'b0} + POS_W'(r_phase);

    always_comb begin
        o_div_req.load     = 1'b1;
        o_div_req.narrow   = 1'b1;
        o_div_req.dividend = DIV_W'(idx_sum);
        o_div_req.divisor  = r_dlen;
        unique case (i_act)
            ACT_TICK_START: begin
                o_div_req.narrow   = 1'b0;
                o_div_req.dividend = r_clock;
                o_div_req.divisor  = sd_eff;
            end
            ACT_PHASE_DIV: begin
                o_div_req.narrow   = 1'b0;
                o_div_req.dividend = DIV_W'(i_cfg.seed) + DIV_W'(r_clock[31:1]);
                o_div_req.divisor  = len_eff;
            end
            ACT_IDX_DIV: o_div_req.load = !o_stat.no_pixel;
            ACT_SCALE_DIV: begin
                o_div_req.dividend = DIV_W'(i_div_rsp.rem) << WAVE_IDX_W;
            end
            default: o_div_req.load = 1'b0;
        endcase
    end

    // rainbow slot that lands on the read pixel
    always_comb begin
        if (r_dfwd) begin
            slot = 11'(r_pix) + 11'(r_dpos) - 11'sd1 - 11'(r_dlen);
        end else begin
            slot = 11'(r_dpos) - 11'sd1 - 11'(r_pix);
        end
        slot_cnt = 6'(RAINBOW_COLORS) * 6'(r_drep);
        in_band  = r_dactive && !slot[10] && (slot[9:0] < 10'(slot_cnt));
        cidx     = '0;
        for (int c = 1; c < RAINBOW_COLORS; c++) begin
            if (slot[9:0] >= 10'(6'(c) * 6'(r_drep))) cidx = cidx + COLOR_IDX_W'(1);
        end
        wave_val = WAVE_ROM[{i_div_rsp.quo[WAVE_IDX_W-1:0], 3'b000} +: 8];
        pix_rgb  = in_band ? RAINBOW[cidx] : {wave_val, wave_val, 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_sweep_pos <= -POS_W'(1);
            r_phase     <= '0;
            r_dpos      <= '0;
            r_dactive   <= 1'b0;
            r_fvalid    <= 1'b0;
            r_dlen      <= LEN_W'(1);
            r_dfwd      <= 1'b0;
            r_drep      <= REP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (emit) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            unique case (i_act)
                ACT_TICK_START: begin
                    if (touch_hit) r_sweep_pos <= POS_W'(len_eff);
                    r_clock <= r_clock + 32'd1;
                end
                ACT_DRAW: begin
                    r_phase  <= i_div_rsp.rem[PHASE_W-1:0];
                    r_dlen   <= len_eff;
                    r_dfwd   <= i_cfg.forward;
                    r_drep   <= rep_eff;
                    r_fvalid <= 1'b1;
                    if (sweep_idle) begin
                        r_dactive <= 1'b0;
                    end else begin
                        r_dpos      <= r_sweep_pos;
                        r_dactive   <= 1'b1;
                        r_sweep_pos <= r_sweep_pos - POS_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix         <= s_axis_tdata[PIX_W:1];
            r_touch       <= s_axis_tdata[0];
            r_res_done    <= 1'b0;
            r_res_redrawn <= 1'b0;
            r_res_color   <= '0;
        end
        if (i_act == ACT_DRAW) begin
            r_res_redrawn <= 1'b1;
            r_res_done    <= (r_sweep_pos == '0);
        end
        if (i_act == ACT_COLOR) r_res_color <= pix_rgb;
        if (emit) begin
            r_out_data <= OUT_DATA_W'({r_res_color, r_res_redrawn, r_res_done});
        end
    end

    assign o_stat.in_valid = s_axis_tvalid;
    assign o_stat.in_read  = (s_axis_tuser[0] == OP_READ);
    assign o_stat.div_busy = i_div_rsp.busy;
    assign o_stat.rem_nz   = (i_div_rsp.rem != '0);
    assign o_stat.no_pixel = !r_fvalid || ({1'b0, r_pix} >= r_dlen);
    assign o_stat.out_free = out_free;

    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !i_div_rsp.busy)
        else $error("item taken while divider busy");

    a_done_redrawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> r_out_data[1])
        else $error("sweep end reported without redraw");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fvalid |-> ({1'b0, r_phase} < r_dlen))
        else $error("latched phase not below latched length");

endmodule

// File: hdl/led_strip_wave_rainbow_animator.sv
// led strip wave rainbow animator top level
//
// one input stream carries items: tuser[0] is the opcode (0 frame tick,
// 1 pixel read), tdata[0] the touch flag, tdata[8:1] the pixel index.
// each item gives exactly one result transaction: tdata[0] sweep_done,
// tdata[1] redrawn, tdata[25:2] the rgb color of a read pixel.
// the apb port holds strip_length, forward, seed, slowdown, retrigger and
// pixel_repeat at byte addresses 0, 4, 8, 12, 16, 20; write only while idle.
// a microprogram steps one item at a time through a bit-serial divider;
// a tick without redraw runs one 32-bit modulo, a tick with redraw
// two, a pixel read two 16-bit divides, a read of an undrawn or
// out-of-range pixel none.
// the result is valid from the same cycle in which the next item can be taken.
// the result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the sequencer at its emit step.
// reset restores the register defaults, idles the sweep and clears the
// drawn frame, so reads return black until the first redraw.
module led_strip_wave_rainbow_animator
    import lswr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // touch, pixel_index
    input  logic [0:0]            s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // sweep_done, redrawn, color
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg     cfg;
    t_act     act;
    t_stat    stat;
    t_div_req div_req;
    t_div_rsp div_rsp;

    lswr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lswr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lswr_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_act   (act)
    );

    lswr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_act         (act),
        .i_cfg         (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_stat        (stat)
    );

endmodule

// File: tb/tb_led_strip_wave_rainbow_animator.sv
// self-checking testbench for the led strip wave rainbow animator
module tb_led_strip_wave_rainbow_animator
    import lswr_pkg::*;
();

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int LONG_HOLD       = 400;
    localparam longint Q30         = 64'sd1073741824;
    localparam longint HALF_PI     = 64'sd1686629713;

    localparam logic [RGB_W-1:0] SWEEP_PALETTE [RAINBOW_COLORS] = '{
        24'hA000FF, 24'h0000FF, 24'h00FF00, 24'hFFFF00, 24'hFF9000, 24'hFF0000
    };

    typedef struct packed {
        logic             done;
        logic             redrawn;
        logic [RGB_W-1:0] color;
    } t_strip_result;

    typedef struct packed {
        logic          op;
        logic          touch;
        logic [7:0]    pix;
        logic          typed;
        t_strip_result want;
    } t_stim_row;

    localparam t_strip_result BLANK       = '0;
    localparam t_strip_result FRESH_FRAME = '{done: 1'b0, redrawn: 1'b1, color: 24'h0};

    // reset register values: length 240, forward, slowdown 2, repeat 2
    localparam t_stim_row DIRECTED [22] = '{
        '{OP_READ, 1'b0, 8'd0,   1'b1, BLANK},       // nothing drawn yet
        '{OP_READ, 1'b1, 8'd255, 1'b1, BLANK},
        '{OP_TICK, 1'b0, 8'd0,   1'b1, FRESH_FRAME}, // idle sweep, background only
        '{OP_TICK, 1'b0, 8'd0,   1'b1, BLANK},       // no redraw
        '{OP_READ, 1'b0, 8'd0,   1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd239, 1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd240, 1'b1, BLANK},       // past the strip end
        '{OP_READ, 1'b0, 8'd255, 1'b1, BLANK},
        '{OP_TICK, 1'b1, 8'd0,   1'b1, FRESH_FRAME}, // sweep starts
        '{OP_READ, 1'b0, 8'd1,   1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd12,  1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd13,  1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd239, 1'b0, BLANK},
        '{OP_TICK, 1'b1, 8'd0,   1'b1, BLANK},       // touch ignored while running
        '{OP_TICK, 1'b0, 8'd0,   1'b1, FRESH_FRAME},
        '{OP_READ, 1'b0, 8'd2,   1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd14,  1'b0, BLANK},
        '{OP_READ, 1'b1, 8'd170, 1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd85,  1'b0, BLANK},
        '{OP_READ, 1'b0, 8'd128, 1'b0, BLANK},
        '{OP_TICK, 1'b1, 8'd255, 1'b1, BLANK},
        '{OP_TICK, 1'b0, 8'd0,   1'b1, FRESH_FRAME}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // touch, pixel_index
    logic [0:0]            s_axis_tuser = '0;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // sweep_done, redrawn, color
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    led_strip_wave_rainbow_animator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // animator shadow state
    t_cfg        cfg = '{strip_length: 9'd240, forward: 1'b1, seed: '0, slowdown: 8'd2,
                         retrigger: 1'b0, pixel_repeat: 4'd2};
    int unsigned frame_clock = 0;
    int          sweep_pos = -1;
    int unsigned drawn_phase = 0;
    int          drawn_pos = 0;
    bit          drawn_active = 1'b0;
    bit          frame_valid = 1'b0;
    int unsigned drawn_len = 1;
    bit          drawn_fwd = 1'b0;
    int unsigned drawn_rep = 1;
    logic [7:0]  wave_lut [WAVE_TABLE_SIZE];

    t_strip_result pending_results [$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  tick_count = 0;
    int  read_count = 0;
    int  redraw_count = 0;
    int  sweep_end_count = 0;
    bit  quiet = 1'b0;
    bit  hold_request = 1'b0;

    initial begin : build_wave_lut
        longint n, p, x, x2, term, sum, c;
        bit     neg;
        for (int k = 0; k < WAVE_TABLE_SIZE; k++) begin
            n   = k;
            neg = 1'b0;
            if (2 * n > WAVE_TABLE_SIZE) n = WAVE_TABLE_SIZE - n;
            p = 4 * n;
            if (p > WAVE_TABLE_SIZE) begin
                p   = 2 * WAVE_TABLE_SIZE - p;
                neg = 1'b1;
            end
            if (p == 0) begin
                c = Q30;
            end else if (p == WAVE_TABLE_SIZE) begin
                c = 0;
            end else begin
                x    = (p * HALF_PI) / WAVE_TABLE_SIZE;
                x2   = (x * x) >>> 30;
                term = Q30;
                sum  = Q30;
                for (int j = 1; j <= 10; j++) begin
                    term = (term * x2) >>> 30;
                    term = term / longint'((2 * j - 1) * (2 * j));
                    if (j % 2 == 1) sum = sum - term;
                    else sum = sum + term;
                end
                if (sum < 0) sum = 0;
                if (sum > Q30) sum = Q30;
                c = sum;
            end
            if (neg) c = -c;
            wave_lut[k] = 8'(64 + (((Q30 + c) * 63) >>> 30));
        end
    end

    function automatic int unsigned strip_span();
        if (cfg.strip_length == 0) return 1;
        if (cfg.strip_length > MAX_LEDS) return MAX_LEDS;
        return cfg.strip_length;
    endfunction

    function automatic t_strip_result animate_item(input logic op, input logic touch,
                                                   input logic [7:0] pix);
        t_strip_result r;
        int unsigned   span, every, old_clock, wave_idx;
        int            q, target;
        logic [7:0]    level;
        r = '0;
        if (op == OP_READ) begin
            read_count++;
            if (frame_valid && int'(pix) < int'(drawn_len)) begin
                wave_idx = (((3 * int'(pix) + drawn_phase) % drawn_len) * WAVE_TABLE_SIZE)
                           / drawn_len;
                level   = wave_lut[wave_idx % WAVE_TABLE_SIZE];
                r.color = {level, level, 8'h00};
                if (drawn_active) begin
                    for (int s = 0; s < RAINBOW_COLORS * int'(drawn_rep); s++) begin
                        q      = drawn_pos - 1 - s;
                        target = drawn_fwd ? int'(drawn_len) - q : q;
                        if (target == int'(pix)) r.color = SWEEP_PALETTE[s / int'(drawn_rep)];
                    end
                end
            end
            return r;
        end
        tick_count++;
        span = strip_span();
        if (touch && (cfg.retrigger || sweep_pos < 0)) sweep_pos = span;
        old_clock   = frame_clock;
        frame_clock = frame_clock + 1;
        every = (cfg.slowdown == 0) ? 1 : cfg.slowdown;
        if (old_clock % every != 0) return r;
        drawn_rep = (cfg.pixel_repeat == 0) ? 1 :
                    (cfg.pixel_repeat > REP_MAX) ? REP_MAX : cfg.pixel_repeat;
        drawn_phase = (cfg.seed + frame_clock / 2) % span;
        drawn_len   = span;
        drawn_fwd   = cfg.forward;
        frame_valid = 1'b1;
        if (sweep_pos < 0) begin
            drawn_active = 1'b0;
        end else begin
            drawn_pos    = sweep_pos;
            drawn_active = 1'b1;
            sweep_pos--;
            r.done = (sweep_pos == -1);
        end
        r.redrawn = 1'b1;
        redraw_count++;
        if (r.done) sweep_end_count++;
        return r;
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STRIP_LENGTH: cfg.strip_length = value[LEN_W-1:0];
            REG_FORWARD:      cfg.forward      = value[0];
            REG_SEED:         cfg.seed         = value[SEED_W-1:0];
            REG_SLOWDOWN:     cfg.slowdown     = value[SLOW_W-1:0];
            REG_RETRIGGER:    cfg.retrigger    = value[0];
            REG_PIXEL_REPEAT: cfg.pixel_repeat = value[REP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg s);
        apb_write(REG_STRIP_LENGTH, 32'(s.strip_length));
        apb_write(REG_FORWARD,      32'(s.forward));
        apb_write(REG_SEED,         32'(s.seed));
        apb_write(REG_SLOWDOWN,     32'(s.slowdown));
        apb_write(REG_RETRIGGER,    32'(s.retrigger));
        apb_write(REG_PIXEL_REPEAT, 32'(s.pixel_repeat));
    endtask

    task automatic offer_item(input logic op, input logic touch, input logic [7:0] pix,
                              input logic typed, input t_strip_result want);
        t_strip_result predicted;
        int            gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({pix, touch});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = animate_item(op, touch, pix);
        pending_results = {pending_results, (typed ? want : predicted)};
    endtask

    task automatic await_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin : drive_result_ready
        int idle_left;
        bit long_hold_done;
        idle_left      = 0;
        long_hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_left > 0) begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request && !long_hold_done) begin
                long_hold_done = 1'b1;
                idle_left      = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_strip_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.done    = m_axis_tdata[0];
            got.redrawn = m_axis_tdata[1];
            got.color   = m_axis_tdata[2 +: RGB_W];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: done %b redrawn %b color %06h",
                             got.done, got.redrawn, got.color);
            end else begin
                want = pending_results.pop_front();
                if (got.done !== want.done || got.redrawn !== want.redrawn ||
                    got.color !== want.color) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected done %b redrawn %b color %06h, got %b %b %06h",
                                 want.done, want.redrawn, want.color,
                                 got.done, got.redrawn, got.color);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : run_stimulus
        t_cfg        plan [NUM_PHASES];
        logic        op, touch;
        logic [7:0]  pix;
        int unsigned span;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            offer_item(DIRECTED[i].op, DIRECTED[i].touch, DIRECTED[i].pix,
                       DIRECTED[i].typed, DIRECTED[i].want);
        await_results();

        plan[0] = '{strip_length: 9'd1,   forward: 1'b0, seed: 31'd0,
                    slowdown: 8'd1,   retrigger: 1'b0, pixel_repeat: 4'd1};
        plan[1] = '{strip_length: 9'd256, forward: 1'b1, seed: 31'h7FFFFFFF,
                    slowdown: 8'd255, retrigger: 1'b1, pixel_repeat: 4'd8};
        plan[2] = '{strip_length: 9'd0,   forward: 1'b1, seed: 31'd5,
                    slowdown: 8'd0,   retrigger: 1'b1, pixel_repeat: 4'd0};
        plan[3] = '{strip_length: 9'd511, forward: 1'b0, seed: 31'd123,
                    slowdown: 8'd3,   retrigger: 1'b0, pixel_repeat: 4'd15};
        plan[4] = '{strip_length: 9'd8,   forward: 1'b1, seed: 31'($urandom),
                    slowdown: 8'd1,   retrigger: 1'b1, pixel_repeat: 4'd3};
        for (int p = 5; p < NUM_PHASES; p++) begin
            plan[p].strip_length = (p == 7) ? 9'($urandom_range(1, 256))
                                            : 9'($urandom_range(1, 20));
            plan[p].forward      = 1'($urandom_range(0, 1));
            plan[p].seed         = 31'($urandom);
            plan[p].slowdown     = 8'($urandom_range(0, 3));
            plan[p].retrigger    = 1'($urandom_range(0, 1));
            plan[p].pixel_repeat = 4'($urandom_range(1, 8));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_setting(plan[p]);
            quiet = (p == 6 || p == NUM_PHASES - 1);
            span  = strip_span();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n == 5) hold_request = 1'b1;
                op    = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_READ;
                touch = ($urandom_range(0, 3) == 0);
                if (op == OP_READ && $urandom_range(0, 9) < 7)
                    pix = 8'($urandom_range(0, span - 1));
                else
                    pix = 8'($urandom_range(0, 255));
                offer_item(op, touch, pix, 1'b0, BLANK);
            end
            await_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d ticks and %0d pixel reads over %0d register settings",
                 tick_count, read_count, NUM_PHASES + 1);
        $display("%0d frames redrawn, %0d sweeps run to the end, %0d mismatches",
                 redraw_count, sweep_end_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
